### rtl/core/lrr_pkg.sv
// Launch retard ramp: shared types, constants and a helper function.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package lrr_pkg;

    localparam int CURVE_POINTS = 8;
    localparam int CP_AW        = (CURVE_POINTS > 1) ? $clog2(CURVE_POINTS) : 1;

    localparam int THR_W    = 10;
    localparam int TS_W     = 32;
    localparam int IDX_W    = 3;
    localparam int TIME_W   = 16;
    localparam int RET_W    = 12;
    localparam int OUT_W    = 11;
    localparam int DV_W     = RET_W + 1;
    localparam int PROD_W   = DV_W + TIME_W + 1;
    localparam int MAG_W    = PROD_W - 1;
    localparam int QUO_W    = RET_W;
    localparam int SUM_W    = QUO_W + 2;
    localparam int DCNT_W   = $clog2(QUO_W + 1);
    localparam int CFG_IW   = 1;
    localparam int CFG_DW   = THR_W;

    localparam logic [THR_W-1:0] WOT_RESET = THR_W'(900);
    localparam logic [OUT_W-1:0] RET_MAX   = {OUT_W{1'b1}};

    localparam logic [CFG_IW-1:0] REG_RAMP_ENABLE   = 1'b0;
    localparam logic [CFG_IW-1:0] REG_WOT_THRESHOLD = 1'b1;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef struct packed {
        logic                     cmd;
        logic                     launch_active;
        logic [THR_W-1:0]         throttle_intent;
        logic [TS_W-1:0]          now_ms;
        logic [IDX_W-1:0]         point_index;
        logic [TIME_W-1:0]        point_time_ms;
        logic signed [RET_W-1:0]  point_retard;
    } in_item_t;

    typedef struct packed {
        logic [OUT_W-1:0]  timing_retard;
        logic              ramp_active;
        logic [TS_W-1:0]   elapsed_ms;
    } out_item_t;

    typedef struct packed {
        logic [TIME_W-1:0]        t;
        logic signed [RET_W-1:0]  r;
    } curve_pt_t;

    typedef struct packed {
        logic              rd_en;
        logic [CP_AW-1:0]  rd_addr;
        logic              wr_en;
        logic [CP_AW-1:0]  wr_addr;
        curve_pt_t         wr_data;
    } mem_req_t;

    typedef struct packed {
        logic               start;
        logic [MAG_W-1:0]   dividend;
        logic [TIME_W-1:0]  divisor;
    } div_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LAST,
        ST_SCAN,
        ST_MUL,
        ST_DSTART,
        ST_DWAIT,
        ST_EMIT
    } state_t;

    function automatic logic [OUT_W-1:0] clamp_retard(input logic signed [SUM_W-1:0] v);
        logic [OUT_W-1:0] res;
        if (v < 0)
        begin
            res = '0;
        end
        else if (v > $signed({{(SUM_W-OUT_W){1'b0}}, RET_MAX}))
        begin
            res = RET_MAX;
        end
        else
        begin
            res = v[OUT_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### rtl/core/launch_retard_ramp_top.sv
// Launch retard ramp top level: control sequencer, ramp state, output register.
// Depends on lrr_pkg, lrr_curve_mem and lrr_div.
// Sequence: a write item or an inactive tick goes from decode to the emit state; an active
// tick reads the last point, then ends the ramp or scans the curve; before the first point
// it emits that point, else it interpolates up to point k (1 to 7): k + 1 curve reads,
// a multiply and 12 divider steps. Throughput: one item at a time; the next transfer is
// taken the cycle after the result enters the output register, once any stall clears.
// Reset: asynchronous, active low; clears ramp state, the sequencer and output valid, and marks all points zero.
`timescale 1ns / 1ps
`default_nettype none

module launch_retard_ramp_top
    import lrr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [CFG_IW-1:0] cfg_index,
    input  wire logic [CFG_DW-1:0] cfg_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire in_item_t          in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output out_item_t              out_data
);

    localparam logic [CP_AW-1:0] LAST_IDX = CP_AW'(CURVE_POINTS - 1);

    state_t                   state_reg, state_next;
    in_item_t                 item_reg;
    logic                     enable_reg;
    logic [THR_W-1:0]         wot_reg;
    logic                     prev_launch_reg, prev_launch_next;
    logic                     active_reg, active_next;
    logic [TS_W-1:0]          start_time_reg, start_time_next;
    logic [TS_W-1:0]          held_elapsed_reg, held_elapsed_next;
    logic [OUT_W-1:0]         held_retard_reg, held_retard_next;
    logic [CP_AW-1:0]         cnt_reg, cnt_next;
    logic [TIME_W-1:0]        prev_t_reg, prev_t_next;
    logic signed [RET_W-1:0]  prev_r_reg, prev_r_next;
    logic [TIME_W-1:0]        span_reg, span_next;
    logic signed [DV_W-1:0]   dv_reg, dv_next;
    logic [TIME_W-1:0]        dt_reg, dt_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    out_item_t                out_reg, out_next;
    logic                     out_valid_reg;
    logic                     load_out;

    mem_req_t                 mreq;
    curve_pt_t                cur;
    div_req_t                 dreq;
    logic                     div_done;
    logic [QUO_W-1:0]         div_q;

    logic                     start_evt;
    logic                     act;
    logic [TS_W-1:0]          st_time;
    logic [PROD_W-1:0]        prod_abs;
    logic signed [SUM_W-1:0]  q_signed;
    logic signed [SUM_W-1:0]  seg_sum;
    logic signed [TIME_W:0]   dt_s;

    lrr_curve_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mreq),
        .rd_data (cur)
    );

    lrr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (dreq),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            wot_reg    <= WOT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RAMP_ENABLE:   enable_reg <= cfg_data[0];
                REG_WOT_THRESHOLD: wot_reg    <= cfg_data[THR_W-1:0];
                default:           ;
            endcase
        end
    end

    assign start_evt = prev_launch_reg && !item_reg.launch_active
                       && (item_reg.throttle_intent >= wot_reg);
    assign act       = active_reg | start_evt;
    assign st_time   = start_evt ? item_reg.now_ms : start_time_reg;
    assign dt_s      = $signed({1'b0, dt_reg});
    assign prod_abs  = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign q_signed  = prod_reg[PROD_W-1] ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});
    assign seg_sum   = SUM_W'(prev_r_reg) + q_signed;

    always_comb
    begin
        state_next        = state_reg;
        prev_launch_next  = prev_launch_reg;
        active_next       = active_reg;
        start_time_next   = start_time_reg;
        held_elapsed_next = held_elapsed_reg;
        held_retard_next  = held_retard_reg;
        cnt_next          = cnt_reg;
        prev_t_next       = prev_t_reg;
        prev_r_next       = prev_r_reg;
        span_next         = span_reg;
        dv_next           = dv_reg;
        dt_next           = dt_reg;
        prod_next         = prod_reg;
        load_out          = 1'b0;
        mreq              = '0;
        mreq.wr_addr      = CP_AW'(item_reg.point_index);
        mreq.wr_data.t    = item_reg.point_time_ms;
        mreq.wr_data.r    = item_reg.point_retard;
        dreq.start        = 1'b0;
        dreq.dividend     = prod_abs[MAG_W-1:0];
        dreq.divisor      = span_reg;
        in_ready          = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (item_reg.cmd == CMD_WRITE)
                begin
                    mreq.wr_en = (32'(item_reg.point_index) < CURVE_POINTS);
                    state_next = ST_EMIT;
                end
                else if (!enable_reg)
                begin
                    active_next       = 1'b0;
                    held_retard_next  = '0;
                    held_elapsed_next = '0;
                    prev_launch_next  = 1'b0;
                    state_next        = ST_EMIT;
                end
                else
                begin
                    start_time_next  = st_time;
                    active_next      = act;
                    prev_launch_next = item_reg.launch_active;
                    if (act)
                    begin
                        held_elapsed_next = item_reg.now_ms - st_time;
                        mreq.rd_en        = 1'b1;
                        mreq.rd_addr      = LAST_IDX;
                        state_next        = ST_LAST;
                    end
                    else
                    begin
                        held_retard_next = '0;
                        state_next       = ST_EMIT;
                    end
                end
            end
            ST_LAST:
            begin
                if (held_elapsed_reg > TS_W'(cur.t))
                begin
                    active_next      = 1'b0;
                    held_retard_next = '0;
                    state_next       = ST_EMIT;
                end
                else
                begin
                    mreq.rd_en   = 1'b1;
                    mreq.rd_addr = '0;
                    cnt_next     = '0;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if ((held_elapsed_reg[TIME_W-1:0] <= cur.t) || (cnt_reg == LAST_IDX))
                begin
                    if (cnt_reg == '0)
                    begin
                        held_retard_next = clamp_retard(SUM_W'(cur.r));
                        state_next       = ST_EMIT;
                    end
                    else
                    begin
                        span_next  = cur.t - prev_t_reg;
                        dv_next    = DV_W'(cur.r) - DV_W'(prev_r_reg);
                        dt_next    = held_elapsed_reg[TIME_W-1:0] - prev_t_reg;
                        state_next = ST_MUL;
                    end
                end
                else
                begin
                    prev_t_next  = cur.t;
                    prev_r_next  = cur.r;
                    cnt_next     = cnt_reg + 1'b1;
                    mreq.rd_en   = 1'b1;
                    mreq.rd_addr = cnt_reg + 1'b1;
                end
            end
            ST_MUL:
            begin
                prod_next  = dv_reg * dt_s;
                state_next = ST_DSTART;
            end
            ST_DSTART:
            begin
                dreq.start = 1'b1;
                state_next = ST_DWAIT;
            end
            ST_DWAIT:
            begin
                if (div_done)
                begin
                    held_retard_next = clamp_retard(seg_sum);
                    state_next       = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_next               = out_reg;
        if (load_out)
        begin
            out_next.timing_retard = active_reg ? held_retard_reg : '0;
            out_next.ramp_active   = active_reg;
            out_next.elapsed_ms    = held_elapsed_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            prev_launch_reg  <= 1'b0;
            active_reg       <= 1'b0;
            start_time_reg   <= '0;
            held_elapsed_reg <= '0;
            held_retard_reg  <= '0;
            cnt_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            prev_launch_reg  <= prev_launch_next;
            active_reg       <= active_next;
            start_time_reg   <= start_time_next;
            held_elapsed_reg <= held_elapsed_next;
            held_retard_reg  <= held_retard_next;
            cnt_reg          <= cnt_next;
            out_valid_reg    <= load_out | (out_valid_reg & ~out_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_data;
        end
        prev_t_reg <= prev_t_next;
        prev_r_reg <= prev_r_next;
        span_reg   <= span_next;
        dv_reg     <= dv_next;
        dt_reg     <= dt_next;
        prod_reg   <= prod_next;
        out_reg    <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

### rtl/core/lrr_curve_mem.sv
// Curve point store: synchronous RAM with registered read.
// Per-entry valid flags make unwritten points read as zero after reset.
// Depends on lrr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lrr_curve_mem
    import lrr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire mem_req_t  req,
    output curve_pt_t      rd_data
);

    curve_pt_t               mem [CURVE_POINTS];
    logic [CURVE_POINTS-1:0] vld_reg;
    curve_pt_t               rd_data_reg;
    logic                    rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                vld_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_vld_reg <= vld_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

### rtl/core/lrr_div.sv
// Restoring divider, one quotient bit per cycle, for the segment interpolation.
// Assumes the quotient fits QUO_W bits; depends on lrr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lrr_div
    import lrr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire div_req_t    req,
    output logic             done,
    output logic [QUO_W-1:0] quotient
);

    logic [DCNT_W-1:0] cnt_reg;
    logic              done_reg;
    logic [TIME_W-1:0] rem_reg;
    logic [QUO_W-1:0]  low_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [TIME_W-1:0] div_reg;

    logic [TIME_W:0]   trial;
    logic              ge;

    assign trial = {rem_reg, low_reg[QUO_W-1]};
    assign ge    = trial >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (req.start)
        begin
            cnt_reg  <= DCNT_W'(QUO_W);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == DCNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.dividend[MAG_W-2:QUO_W];
            low_reg <= req.dividend[QUO_W-1:0];
            div_reg <= req.divisor;
            quo_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= ge ? TIME_W'(trial - {1'b0, div_reg}) : trial[TIME_W-1:0];
            low_reg <= {low_reg[QUO_W-2:0], 1'b0};
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

### rtl/core/lrr_checker.sv
// Port-level checks for the launch retard ramp, bound to the top level.
// Depends on lrr_pkg and launch_retard_ramp_top.
`timescale 1ns / 1ps
`default_nettype none

module lrr_checker
    import lrr_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire out_item_t         out_data
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // retard is zero whenever the ramp is reported inactive
    a_idle_zero: assert property (@(posedge clk)
        out_valid && !out_data.ramp_active |-> out_data.timing_retard == '0)
        else $error("retard shown with ramp inactive");

    // one item in flight: drop ready after a transfer
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transfer taken while busy");

    // no result straight out of reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

endmodule

bind launch_retard_ramp_top lrr_checker u_lrr_checker (.*);

`default_nettype wire

### tb/lrr_ramp_check.sv
// Launch retard ramp checker: mirrors the register writes, predicts one result per
// input transfer and compares every output transfer against the oldest prediction.
// Depends on lrr_pkg only.
`timescale 1ns / 1ps

module lrr_ramp_check
    import lrr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [CFG_IW-1:0] cfg_index,
    input  wire logic [CFG_DW-1:0] cfg_data,
    input  wire logic              in_valid,
    input  wire logic              in_ready,
    input  wire in_item_t          in_data,
    input  wire logic              out_valid,
    input  wire logic              out_ready,
    input  wire out_item_t         out_data,
    output int                     fault_count,
    output int                     outstanding,
    output int                     ramps_started,
    output int                     results_checked
);

    logic                    enable_q;
    logic [THR_W-1:0]        wot_q;
    logic                    launch_q;
    logic                    running;
    logic [TS_W-1:0]         t_start;
    logic [TS_W-1:0]         elapsed_q;
    logic [OUT_W-1:0]        retard_q;
    logic [TIME_W-1:0]       pt_time [CURVE_POINTS];
    logic signed [RET_W-1:0] pt_ret [CURVE_POINTS];
    out_item_t               retard_due [$];
    out_item_t               want;

    function automatic longint curve_value(input logic [TS_W-1:0] t);
        longint lo_t;
        longint span;
        longint lo_r;
        longint dv;
        if (t <= pt_time[0])
        begin
            return pt_ret[0];
        end
        for (int i = 1; i < CURVE_POINTS; i++)
        begin
            if (t <= pt_time[i])
            begin
                lo_t = pt_time[i-1];
                span = longint'(pt_time[i]) - lo_t;
                lo_r = pt_ret[i-1];
                dv   = longint'(pt_ret[i]) - lo_r;
                if (span <= 0)
                begin
                    return pt_ret[i];
                end
                return lo_r + (dv * (longint'(t) - lo_t)) / span;
            end
        end
        return pt_ret[CURVE_POINTS-1];
    endfunction

    task automatic predict_ramp(input in_item_t it, output out_item_t res);
        longint r;
        if (it.cmd == CMD_WRITE)
        begin
            if (it.point_index < CURVE_POINTS)
            begin
                pt_time[it.point_index] = it.point_time_ms;
                pt_ret[it.point_index]  = it.point_retard;
            end
        end
        else if (!enable_q)
        begin
            running   = 1'b0;
            retard_q  = '0;
            elapsed_q = '0;
            launch_q  = 1'b0;
        end
        else
        begin
            if (launch_q && !it.launch_active && it.throttle_intent >= wot_q)
            begin
                t_start = it.now_ms;
                running = 1'b1;
                ramps_started++;
            end
            launch_q = it.launch_active;
            if (running)
            begin
                elapsed_q = it.now_ms - t_start;
                if (elapsed_q > pt_time[CURVE_POINTS-1])
                begin
                    running  = 1'b0;
                    retard_q = '0;
                end
                else
                begin
                    r = curve_value(elapsed_q);
                    if (r < 0)
                    begin
                        r = 0;
                    end
                    if (r > longint'(RET_MAX))
                    begin
                        r = longint'(RET_MAX);
                    end
                    retard_q = OUT_W'(r);
                end
            end
            else
            begin
                retard_q = '0;
            end
        end
        res.timing_retard = running ? retard_q : '0;
        res.ramp_active   = running;
        res.elapsed_ms    = elapsed_q;
    endtask

    task automatic report_fault(input string what, input longint got_v, input longint want_v);
        fault_count++;
        $display("[%0t] %s: got %0d, expected %0d", $time, what, got_v, want_v);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_q        = 1'b0;
            wot_q           = WOT_RESET;
            launch_q        = 1'b0;
            running         = 1'b0;
            t_start         = '0;
            elapsed_q       = '0;
            retard_q        = '0;
            fault_count     = 0;
            ramps_started   = 0;
            results_checked = 0;
            for (int i = 0; i < CURVE_POINTS; i++)
            begin
                pt_time[i] = '0;
                pt_ret[i]  = '0;
            end
            retard_due.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_RAMP_ENABLE)
                begin
                    enable_q = cfg_data[0];
                end
                else if (cfg_index == REG_WOT_THRESHOLD)
                begin
                    wot_q = cfg_data[THR_W-1:0];
                end
            end
            if (in_valid && in_ready)
            begin
                predict_ramp(in_data, want);
                retard_due.push_back(want);
            end
            if (out_valid && out_ready)
            begin
                results_checked++;
                if (retard_due.size() == 0)
                begin
                    report_fault("result with nothing outstanding, retard",
                                 out_data.timing_retard, 0);
                end
                else
                begin
                    want = retard_due.pop_front();
                    if (out_data.timing_retard !== want.timing_retard)
                    begin
                        report_fault("timing_retard", out_data.timing_retard,
                                     want.timing_retard);
                    end
                    if (out_data.ramp_active !== want.ramp_active)
                    begin
                        report_fault("ramp_active", out_data.ramp_active, want.ramp_active);
                    end
                    if (out_data.elapsed_ms !== want.elapsed_ms)
                    begin
                        report_fault("elapsed_ms", out_data.elapsed_ms, want.elapsed_ms);
                    end
                end
            end
        end
        outstanding = retard_due.size();
    end

endmodule

### tb/launch_retard_ramp_top_test.sv
// Launch retard ramp testbench top: clock, reset, register writes, paced stimulus and verdict.
// Depends on lrr_pkg, launch_retard_ramp_top and lrr_ramp_check.
`timescale 1ns / 1ps

module launch_retard_ramp_top_test;
    import lrr_pkg::*;

    localparam int PHASES = 6;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [CFG_IW-1:0] cfg_index;
    logic [CFG_DW-1:0] cfg_data;
    logic              in_valid;
    logic              in_ready;
    in_item_t          in_data;
    logic              out_valid;
    logic              out_ready = 1'b0;
    out_item_t         out_data;

    int                fault_count;
    int                outstanding;
    int                ramps_started;
    int                results_checked;

    int                items_sent = 0;
    int                points_written = 0;
    int                burst_left = 8;
    logic [TS_W-1:0]   clock_ms = '0;
    logic [THR_W-1:0]  wot_now = WOT_RESET;
    int                last_point_ms = 0;

    int                stall_phase = 0;
    logic [15:0]       stall_word = 16'hFFFF;

    always #2 clk = ~clk;

    launch_retard_ramp_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    lrr_ramp_check ramp_check
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_data        (out_data),
        .fault_count     (fault_count),
        .outstanding     (outstanding),
        .ramps_started   (ramps_started),
        .results_checked (results_checked)
    );

    // draw a fresh sixteen-bit stall pattern per sweep, often with no stalls at all
    always @(negedge clk)
    begin
        if (stall_phase == 0)
        begin
            case ($urandom_range(0, 3))
                0: stall_word = 16'hFFFF;
                1: stall_word = 16'($urandom);
                default: stall_word = 16'($urandom) | 16'($urandom);
            endcase
        end
        out_ready <= stall_word[stall_phase];
        stall_phase = (stall_phase + 1) % 16;
    end

    task automatic push_item(input in_item_t it);
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        items_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task automatic tick(input logic launch, input logic [THR_W-1:0] thr);
        in_item_t it;
        it.cmd             = CMD_TICK;
        it.launch_active   = launch;
        it.throttle_intent = thr;
        it.now_ms          = clock_ms;
        it.point_index     = IDX_W'($urandom);
        it.point_time_ms   = TIME_W'($urandom);
        it.point_retard    = RET_W'($urandom);
        push_item(it);
    endtask

    task automatic put_point(input int idx, input int t, input logic signed [RET_W-1:0] r);
        in_item_t it;
        it.cmd             = CMD_WRITE;
        it.launch_active   = 1'($urandom);
        it.throttle_intent = THR_W'($urandom);
        it.now_ms          = $urandom;
        it.point_index     = IDX_W'(idx);
        it.point_time_ms   = TIME_W'(t);
        it.point_retard    = r;
        if (idx == CURVE_POINTS - 1)
        begin
            last_point_ms = t;
        end
        points_written++;
        push_item(it);
    endtask

    function automatic logic signed [RET_W-1:0] random_retard();
        if ($urandom_range(0, 7) == 0)
        begin
            return RET_W'($urandom);
        end
        return RET_W'($urandom_range(0, 4000) - 2000);
    endfunction

    task automatic set_regs(input logic en, input logic [THR_W-1:0] wot);
        cfg_we    <= 1'b1;
        cfg_index <= REG_RAMP_ENABLE;
        cfg_data  <= CFG_DW'(en);
        @(negedge clk);
        cfg_index <= REG_WOT_THRESHOLD;
        cfg_data  <= wot;
        @(negedge clk);
        cfg_we    <= 1'b0;
        wot_now = wot;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (20) @(negedge clk);
    endtask

    task automatic load_curve();
        int  t;
        int  step_cap;
        bit  ordered;
        ordered  = ($urandom_range(0, 4) != 0);
        step_cap = ($urandom_range(0, 5) == 0) ? 9000 : 400;
        t        = $urandom_range(0, step_cap);
        for (int i = 0; i < CURVE_POINTS; i++)
        begin
            if (!ordered)
            begin
                t = $urandom_range(0, 65535);
            end
            put_point(i, t, random_retard());
            t = t + $urandom_range(0, step_cap);
            if (t > 65535)
            begin
                t = 65535;
            end
        end
    endtask

    task automatic launch_episode();
        int               steps;
        int               step_max;
        logic [THR_W-1:0] thr;
        if ($urandom_range(0, 3) == 0)
        begin
            clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
        end
        repeat ($urandom_range(1, 3))
        begin
            clock_ms += $urandom_range(0, 40);
            tick(1'b1, THR_W'($urandom_range(0, 1023)));
        end
        if ($urandom_range(0, 4) != 0)
        begin
            thr = THR_W'($urandom_range(wot_now, (wot_now > 1000) ? 1023 : 1000));
        end
        else
        begin
            thr = THR_W'($urandom_range(0, 1000));
        end
        clock_ms += $urandom_range(0, 40);
        tick(1'b0, thr);
        step_max = last_point_ms / 5 + 1;
        steps    = $urandom_range(3, 12);
        repeat (steps)
        begin
            case ($urandom_range(0, 15))
                0: put_point($urandom_range(0, CURVE_POINTS - 1), $urandom_range(0, 65535),
                             random_retard());
                1:
                begin
                    clock_ms += $urandom_range(0, 40);
                    tick(1'b1, THR_W'($urandom_range(0, 1023)));
                end
                default:
                begin
                    clock_ms += $urandom_range(0, step_max);
                    tick(1'b0, THR_W'($urandom_range(0, 1023)));
                end
            endcase
        end
    endtask

    task automatic noise_item();
        if ($urandom_range(0, 3) == 0)
        begin
            clock_ms = $urandom;
        end
        else
        begin
            clock_ms += $urandom_range(0, 500);
        end
        tick(1'($urandom), THR_W'($urandom_range(0, 1023)));
    endtask

    initial
    begin
        #4_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        logic [TS_W-1:0]  base;
        logic             phase_en;
        logic [THR_W-1:0] phase_wot;
        int               quota;
        int               target;
        int               pick;
        bit               paused;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_data   = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // disabled: ticks give zeros, curve loads still land
        clock_ms = 32'd10;
        tick(1'b1, 10'd1000);
        clock_ms = 32'd20;
        tick(1'b0, 10'd1000);
        put_point(0, 100, 12'sd1500);
        put_point(1, 300, 12'sd2000);
        put_point(2, 600, -12'sd500);
        put_point(3, 900, -12'sd2048);
        put_point(4, 1200, 12'sd2047);
        put_point(5, 1500, 12'sd800);
        put_point(6, 2000, 12'sd0);
        put_point(7, 2100, 12'sd300);

        settle();
        set_regs(1'b1, 10'd900);

        // release below threshold, then a valid release just before the stamp wraps
        base = 32'hFFFF_FFC0;
        clock_ms = base - 32'd30;
        tick(1'b1, 10'd0);
        clock_ms = base - 32'd20;
        tick(1'b0, 10'd899);
        clock_ms = base - 32'd10;
        tick(1'b1, 10'd900);
        clock_ms = base;
        tick(1'b0, 10'd900);
        put_point(3, 900, -12'sd2048);
        clock_ms = base + 32'd200;
        tick(1'b0, 10'd0);
        clock_ms = base + 32'd450;
        tick(1'b0, 10'd0);
        clock_ms = base + 32'd599;
        tick(1'b0, 10'd1023);
        clock_ms = base + 32'd1350;
        tick(1'b0, 10'd0);
        clock_ms = base + 32'd2100;
        tick(1'b0, 10'd0);
        clock_ms = base + 32'd2101;
        tick(1'b0, 10'd0);
        put_point(7, 2100, 12'sd300);
        clock_ms = base + 32'd2200;
        tick(1'b0, 10'd1000);

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: begin phase_en = 1'b1; phase_wot = 10'd900;  end
                1: begin phase_en = 1'b1; phase_wot = 10'd0;    end
                2: begin phase_en = 1'b0; phase_wot = 10'd512;  end
                3: begin phase_en = 1'b1; phase_wot = 10'd1000; end
                4: begin phase_en = 1'b1; phase_wot = 10'd1023; end
                default: begin phase_en = 1'b1; phase_wot = 10'd700; end
            endcase
            settle();
            set_regs(phase_en, phase_wot);
            quota  = phase_en ? 320 : 120;
            target = items_sent + quota;
            paused = 1'b0;
            while (items_sent < target)
            begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                begin
                    load_curve();
                end
                else if (pick < 4)
                begin
                    noise_item();
                end
                else
                begin
                    launch_episode();
                end
                if (!paused && items_sent > target - quota / 2)
                begin
                    settle();
                    paused = 1'b1;
                end
            end
        end

        in_valid <= 1'b0;
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (60) @(negedge clk);

        $display("Covered %0d transfers (%0d curve point writes) under six register settings,",
                 items_sent, points_written);
        $display("with %0d ramp starts and %0d results compared.", ramps_started,
                 results_checked);
        if (fault_count == 0 && outstanding == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
